>>> rtl/comment_header_parser_core_assert.svh
// ============================================================================
// comment header parser assertion macros
// shared property forms for the comment header parser core and its parts
// ============================================================================
`ifndef COMMENT_HEADER_PARSER_CORE_ASSERT_SVH
`define COMMENT_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CHP_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("comment header parser: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define CHP_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("comment header parser: next-cycle check failed");

`endif

>>> rtl/chp_pkg.sv
// ============================================================================
// chp_pkg
// types, codes and constants shared by the comment header parser modules
// ============================================================================
`timescale 1ns / 1ps

package chp_pkg;

    // parse phase, one-hot
    typedef enum logic [7:0] {
        PH_MAGIC = 8'b0000_0001,
        PH_VLEN  = 8'b0000_0010,
        PH_VTEXT = 8'b0000_0100,
        PH_COUNT = 8'b0000_1000,
        PH_CLEN  = 8'b0001_0000,
        PH_CTEXT = 8'b0010_0000,
        PH_TRAIL = 8'b0100_0000,
        PH_ERROR = 8'b1000_0000
    } phase_t;

    // byte class codes
    localparam logic [2:0] CLS_MAGIC = 3'd0;
    localparam logic [2:0] CLS_VLEN  = 3'd1;
    localparam logic [2:0] CLS_VTEXT = 3'd2;
    localparam logic [2:0] CLS_COUNT = 3'd3;
    localparam logic [2:0] CLS_CLEN  = 3'd4;
    localparam logic [2:0] CLS_CTEXT = 3'd5;
    localparam logic [2:0] CLS_TRAIL = 3'd6;
    localparam logic [2:0] CLS_ERROR = 3'd7;

    // packet status codes
    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_OK_TRAIL  = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    // header magic and minimum packet size
    localparam logic [7:0] MAGIC_TEXT [8] = '{
        8'h4F, 8'h70, 8'h75, 8'h73, 8'h54, 8'h61, 8'h67, 8'h73
    };
    localparam logic [4:0] MIN_BYTES = 5'd16;
    localparam logic [31:0] MAGIC_LEN = 32'd8;

    // one result item
    typedef struct packed {
        logic [2:0]  byte_class;
        logic [31:0] comment_index;
        logic [31:0] field_value;
        logic        field_done;
        logic [2:0]  status;
        logic [31:0] trailing_count;
    } result_t;

    // class of a byte seen in a given phase
    function automatic logic [2:0] phase_class(input phase_t ph);
        logic [2:0] cls;
        case (ph)
            PH_MAGIC: cls = CLS_MAGIC;
            PH_VLEN:  cls = CLS_VLEN;
            PH_VTEXT: cls = CLS_VTEXT;
            PH_COUNT: cls = CLS_COUNT;
            PH_CLEN:  cls = CLS_CLEN;
            PH_CTEXT: cls = CLS_CTEXT;
            PH_TRAIL: cls = CLS_TRAIL;
            default:  cls = CLS_ERROR;
        endcase
        return cls;
    endfunction

endpackage

>>> rtl/comment_header_parser_core.sv
// ============================================================================
// comment_header_parser_core
// streaming parser for a comment header packet, one byte per request
// ============================================================================
// usage:
//   item channel: data_byte and last_byte with item_valid / item_stall;
//   a request is taken on a clock edge with item_valid high and item_stall low.
//   result channel: byte_class, comment_index, field_value, field_done, status,
//   trailing_count with result_valid / result_stall.
//   every byte gives exactly one result. the byte is parsed combinationally
//   against the parse state and lands in the result register, so the result
//   shows in the cycle after the byte is taken.
//   throughput is one byte per cycle while the receiver does not stall; the
//   result register lets a new byte be taken in the same cycle the previous result is taken.
//   when the receiver stalls, the result register holds and item_stall rises,
//   so at most one result waits and no byte is taken until it drains.
//   status is nonzero only on the result of a byte marked last_byte; the
//   parse state then returns to its start for the next packet.
//   reset (rst_n low, asynchronous) empties the result register and puts the
//   parser at the start of the magic.
// ============================================================================
`timescale 1ns / 1ps
`include "comment_header_parser_core_assert.svh"

module comment_header_parser_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  byte_class,
    output logic [31:0] comment_index,
    output logic [31:0] field_value,
    output logic        field_done,
    output logic [2:0]  status,
    output logic [31:0] trailing_count
);
    import chp_pkg::*;

    logic    take;
    logic    result_valid_reg;
    result_t res;
    result_t res_reg;

    // accept whenever the result register is empty or being drained
    assign item_stall = result_valid_reg && result_stall;
    assign take       = item_valid && !item_stall;

    chp_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res       (res)
    );

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res;
        end
    end

    // output ports
    assign result_valid   = result_valid_reg;
    assign byte_class     = res_reg.byte_class;
    assign comment_index  = res_reg.comment_index;
    assign field_value    = res_reg.field_value;
    assign field_done     = res_reg.field_done;
    assign status         = res_reg.status;
    assign trailing_count = res_reg.trailing_count;

    // a taken last byte always brings a final status
    `CHP_ASSERT_NEXT(a_last_status, clk, rst_n, take && last_byte, result_valid_reg && res_reg.status != ST_NONE)
    // decoded fields only come on length or count bytes
    `CHP_ASSERT_IMPL(a_done_class, clk, rst_n, result_valid_reg && res_reg.field_done, res_reg.byte_class == CLS_VLEN || res_reg.byte_class == CLS_COUNT || res_reg.byte_class == CLS_CLEN)
    // a trailing count is only reported with the trailing status
    `CHP_ASSERT_IMPL(a_trail_status, clk, rst_n, result_valid_reg && res_reg.trailing_count != 32'd0, res_reg.status == ST_OK_TRAIL)

endmodule

>>> rtl/chp_parse.sv
// ============================================================================
// chp_parse
// parse state and per-byte next-state logic; gives the result of the
// byte offered on its inputs and updates state when that byte is taken
// ============================================================================
`timescale 1ns / 1ps
`include "comment_header_parser_core_assert.svh"

module chp_parse #(
    parameter int LENGTH_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output chp_pkg::result_t  res
);
    import chp_pkg::*;

    localparam logic [31:0] LEN_MAX = 32'((64'd1 << LENGTH_BITS) - 64'd1);

    phase_t      phase_reg,   phase_next;
    logic [31:0] remain_reg,  remain_next;
    logic [1:0]  shift_reg,   shift_next;
    logic [31:0] left_reg,    left_next;
    logic [31:0] comment_reg, comment_next;
    logic [4:0]  seen_reg,    seen_next;
    logic        bad_reg,     bad_next;
    logic [31:0] trail_reg,   trail_next;

    logic [31:0] acc;
    logic [31:0] clamped;
    logic [31:0] remain_dec;
    logic [31:0] left_dec;
    logic        magic_ok;
    logic        do_finish;

    logic        ph_field;
    logic        ph_magic_err;
    logic        ph_comment;

    // shared arithmetic on the current state
    always_comb
    begin
        acc        = remain_reg | ({24'd0, data_byte} << {shift_reg, 3'b000});
        clamped    = (acc > LEN_MAX) ? LEN_MAX : acc;
        remain_dec = (remain_reg != 32'd0) ? remain_reg - 32'd1 : 32'd0;
        left_dec   = (left_reg != 32'd0) ? left_reg - 32'd1 : 32'd0;
        magic_ok   = (data_byte == MAGIC_TEXT[3'd0 - remain_reg[2:0]]);
    end

    // next state and result for the offered byte
    always_comb
    begin
        phase_next   = phase_reg;
        remain_next  = remain_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        comment_next = comment_reg;
        seen_next    = (seen_reg < MIN_BYTES) ? seen_reg + 5'd1 : seen_reg;
        bad_next     = bad_reg;
        trail_next   = trail_reg;
        do_finish    = 1'b0;

        res.byte_class     = phase_class(phase_reg);
        res.comment_index  = comment_reg;
        res.field_value    = 32'd0;
        res.field_done     = 1'b0;
        res.status         = ST_NONE;
        res.trailing_count = 32'd0;

        case (phase_reg)
            PH_MAGIC:
            begin
                if (!magic_ok)
                begin
                    bad_next = 1'b1;
                end
                remain_next = remain_dec;
                if (remain_dec == 32'd0)
                begin
                    phase_next = bad_next ? PH_ERROR : PH_VLEN;
                    shift_next = 2'd0;
                end
            end
            PH_VLEN, PH_COUNT, PH_CLEN:
            begin
                remain_next = acc;
                shift_next  = shift_reg + 2'd1;
                if (shift_reg == 2'd3)
                begin
                    res.field_value = clamped;
                    res.field_done  = 1'b1;
                    remain_next     = 32'd0;
                    shift_next      = 2'd0;
                    if (phase_reg == PH_VLEN)
                    begin
                        if (clamped == 32'd0)
                        begin
                            phase_next = PH_COUNT;
                        end
                        else
                        begin
                            phase_next  = PH_VTEXT;
                            remain_next = clamped;
                        end
                    end
                    else if (phase_reg == PH_COUNT)
                    begin
                        left_next  = clamped;
                        phase_next = (clamped == 32'd0) ? PH_TRAIL : PH_CLEN;
                    end
                    else
                    begin
                        if (clamped == 32'd0)
                        begin
                            do_finish = 1'b1;
                        end
                        else
                        begin
                            phase_next  = PH_CTEXT;
                            remain_next = clamped;
                        end
                    end
                end
            end
            PH_VTEXT, PH_CTEXT:
            begin
                remain_next = remain_dec;
                if (remain_dec == 32'd0)
                begin
                    if (phase_reg == PH_VTEXT)
                    begin
                        phase_next = PH_COUNT;
                        shift_next = 2'd0;
                    end
                    else
                    begin
                        do_finish = 1'b1;
                    end
                end
            end
            PH_TRAIL:
            begin
                if (trail_reg != 32'hFFFF_FFFF)
                begin
                    trail_next = trail_reg + 32'd1;
                end
            end
            default:
            begin
            end
        endcase

        // end of one comment: advance index, go to next length or trailer
        if (do_finish)
        begin
            if (comment_reg != 32'hFFFF_FFFF)
            begin
                comment_next = comment_reg + 32'd1;
            end
            left_next = left_dec;
            if (left_dec == 32'd0)
            begin
                phase_next = PH_TRAIL;
            end
            else
            begin
                phase_next  = PH_CLEN;
                remain_next = 32'd0;
                shift_next  = 2'd0;
            end
        end

        // packet end: status, then back to the start of a packet
        if (last_byte)
        begin
            if (seen_next < MIN_BYTES)
            begin
                res.status = ST_SHORT;
            end
            else if (bad_next)
            begin
                res.status = ST_BAD_MAGIC;
            end
            else if (phase_next == PH_TRAIL)
            begin
                if (comment_next != 32'd0 && trail_next != 32'd0)
                begin
                    res.status         = ST_OK_TRAIL;
                    res.trailing_count = trail_next;
                end
                else
                begin
                    res.status = ST_OK;
                end
            end
            else
            begin
                res.status = ST_TRUNC;
            end
            phase_next   = PH_MAGIC;
            remain_next  = MAGIC_LEN;
            shift_next   = 2'd0;
            left_next    = 32'd0;
            comment_next = 32'd0;
            seen_next    = 5'd0;
            bad_next     = 1'b0;
            trail_next   = 32'd0;
        end
    end

    // state registers, updated on each taken byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC;
            remain_reg  <= MAGIC_LEN;
            shift_reg   <= 2'd0;
            left_reg    <= 32'd0;
            comment_reg <= 32'd0;
            seen_reg    <= 5'd0;
            bad_reg     <= 1'b0;
            trail_reg   <= 32'd0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
            shift_reg   <= shift_next;
            left_reg    <= left_next;
            comment_reg <= comment_next;
            seen_reg    <= seen_next;
            bad_reg     <= bad_next;
            trail_reg   <= trail_next;
        end
    end

    // phase groups used by the checks below
    assign ph_field     = (phase_reg == PH_VLEN) || (phase_reg == PH_COUNT) ||
                          (phase_reg == PH_CLEN);
    assign ph_magic_err = (phase_reg == PH_MAGIC) || (phase_reg == PH_ERROR);
    assign ph_comment   = (phase_reg == PH_CLEN) || (phase_reg == PH_CTEXT);

    // byte position only advances inside a length or count field
    `CHP_ASSERT_IMPL(a_shift_in_field, clk, rst_n, shift_reg != 2'd0, ph_field)
    // a bad magic byte only ever leads to the error phase
    `CHP_ASSERT_IMPL(a_bad_phase, clk, rst_n, bad_reg, ph_magic_err)
    // comments still owed only while inside the comment list
    `CHP_ASSERT_IMPL(a_left_in_comment, clk, rst_n, left_reg != 32'd0, ph_comment)

endmodule
